FILE: hdl/esfd_pkg.sv
// Shared types, constants and calendar helpers for the epoch-seconds to FAT
// date/time converter. No dependencies; every other file of the block but esfd_checker imports it.
package esfd_pkg;

  localparam int unsigned EpochW   = 32;
  localparam int unsigned DaysW    = 16;  // days since 1970 stay below 49711
  localparam int unsigned YearOffW = 8;   // years since 1970, at most 136
  localparam int unsigned MonthW   = 4;
  localparam int unsigned RemW     = 6;   // remainder of a division by 60 or 24
  localparam int unsigned QDepth   = 2;

  // Reciprocals for exact division of any 32-bit value: q = (t * Recip) >> Shift.
  localparam logic [EpochW-1:0]    RecipSixty     = 32'h8888_8889;  // ceil(2^37 / 60)
  localparam int unsigned          ShiftSixty     = 37;
  localparam logic [EpochW-1:0]    RecipDay       = 32'hAAAA_AAAB;  // ceil(2^36 / 24)
  localparam int unsigned          ShiftDay       = 36;
  localparam logic [RemW-1:0]      Sixty          = 6'd60;
  localparam logic [RemW-1:0]      DayHours       = 6'd24;
  localparam logic [YearOffW-1:0]  FatYearOff     = 8'd10;   // 1980 - 1970
  localparam logic [YearOffW-1:0]  NonLeapCentOff = 8'd130;  // 2100 - 1970
  localparam logic [MonthW-1:0]    LastMonth      = 4'd11;   // December, zero based

  typedef enum logic [1:0] {
    PH_SEC,
    PH_MIN,
    PH_HOUR
  } div_phase_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_YEAR,
    B_MONTH,
    B_DONE
  } back_state_e;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic             zero;
    logic [DaysW-1:0] days;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [4:0]       half_sec;
  } esfd_item_t;

  // Leap rule over 1970..2106: year divisible by 4, except 2100.
  // 1970 + off is a multiple of 4 exactly when off mod 4 is 2.
  function automatic logic is_leap(logic [YearOffW-1:0] off);
    return (off[1:0] == 2'd2) && (off != NonLeapCentOff);
  endfunction

  function automatic logic [8:0] year_len(logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(logic [MonthW-1:0] m, logic leap);
    logic [4:0] d;
    unique case (m)
      4'd1:                      d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/esfd_front.sv
// Front end: accepts seconds, splits off second, minute and hour by
// reciprocal multiplication, one division a cycle, and hands the day count on.
// Depends on esfd_pkg.
module esfd_front import esfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [EpochW-1:0] epoch_seconds_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output esfd_item_t        push_item_o
);

  front_state_e      state_q, state_d;
  div_phase_e        phase_q, phase_d;
  logic [EpochW-1:0] work_q, work_d;
  logic [RemW-1:0]   sec_q, sec_d;
  logic [RemW-1:0]   min_q, min_d;
  logic [4:0]        hour_q, hour_d;
  logic              zero_q, zero_d;

  logic [EpochW-1:0]   recip;
  logic [2*EpochW-1:0] prod;
  logic [EpochW-1:0]   quo_nx;
  logic [RemW-1:0]     quo_lo;
  logic [RemW-1:0]     back_mul;
  logic [RemW-1:0]     rem_nx;

  // Divide by 60 or 24 with one reciprocal multiply; the remainder is below 64,
  // so only the low bits of quotient times divisor are needed.
  always_comb begin
    recip = (phase_q == PH_HOUR) ? RecipDay : RecipSixty;
    prod  = work_q * recip;
    if (phase_q == PH_HOUR) quo_nx = EpochW'(prod[2*EpochW-1:ShiftDay]);
    else                    quo_nx = EpochW'(prod[2*EpochW-1:ShiftSixty]);
    quo_lo   = quo_nx[RemW-1:0];
    back_mul = (phase_q == PH_HOUR) ? quo_lo * DayHours : quo_lo * Sixty;
    rem_nx   = work_q[RemW-1:0] - back_mul;
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    work_d  = work_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    zero_d  = zero_q;
    in_stall_o   = 1'b1;
    push_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          work_d  = epoch_seconds_i;
          phase_d = PH_SEC;
          zero_d  = (epoch_seconds_i == '0);
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        work_d = quo_nx;
        unique case (phase_q)
          PH_SEC: begin
            sec_d   = rem_nx;
            phase_d = PH_MIN;
          end
          PH_MIN: begin
            min_d   = rem_nx;
            phase_d = PH_HOUR;
          end
          default: begin
            hour_d  = rem_nx[4:0];
            state_d = F_PUSH;
          end
        endcase
      end
      F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign push_item_o.zero     = zero_q;
  assign push_item_o.days     = work_q[DaysW-1:0];
  assign push_item_o.hour     = hour_q;
  assign push_item_o.minute   = min_q;
  assign push_item_o.half_sec = sec_q[RemW-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      phase_q <= PH_SEC;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    zero_q <= zero_d;
  end

endmodule

FILE: hdl/esfd_queue.sv
// Two-entry queue that decouples the division front from the calendar back.
// Depends on esfd_pkg for the item type and depth.
module esfd_queue import esfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  esfd_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output esfd_item_t pop_item_o
);

  esfd_item_t entries_q [QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'(QDepth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      priority if (do_push && !do_pop) count_q <= count_q + 2'd1;
      else if (do_pop && !do_push)     count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_item_i;
  end

endmodule

FILE: hdl/esfd_back.sv
// Back end: walks years from 1970 and months of the year reached, one step
// a cycle, then packs the FAT words into the output register. Uses esfd_pkg.
module esfd_back import esfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  esfd_item_t pop_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [15:0] fat_date_o,
  output logic [15:0] fat_time_o,
  output logic       zero_result_o
);

  back_state_e         state_q, state_d;
  logic [DaysW-1:0]    days_q, days_d;
  logic [YearOffW-1:0] off_q, off_d;
  logic [MonthW-1:0]   month_q, month_d;
  logic [4:0]          hour_q, hour_d;
  logic [5:0]          min_q, min_d;
  logic [4:0]          hsec_q, hsec_d;
  logic                zero_q, zero_d;

  logic                out_valid_q, out_valid_d;
  logic [15:0]         date_q, date_d;
  logic [15:0]         time_q, time_d;
  logic                zres_q, zres_d;

  logic                leap;
  logic [DaysW-1:0]    ylen, mlen;
  logic [YearOffW-1:0] fat_year;
  logic                out_free;

  assign leap     = is_leap(off_q);
  assign ylen     = DaysW'(year_len(leap));
  assign mlen     = DaysW'(month_len(month_q, leap));
  assign fat_year = off_q - FatYearOff;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    days_d  = days_q;
    off_d   = off_q;
    month_d = month_q;
    hour_d  = hour_q;
    min_d   = min_q;
    hsec_d  = hsec_q;
    zero_d  = zero_q;
    date_d  = date_q;
    time_d  = time_q;
    zres_d  = zres_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_ready_o = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          days_d  = pop_item_i.days;
          hour_d  = pop_item_i.hour;
          min_d   = pop_item_i.minute;
          hsec_d  = pop_item_i.half_sec;
          zero_d  = pop_item_i.zero;
          off_d   = '0;
          month_d = '0;
          state_d = pop_item_i.zero ? B_DONE : B_YEAR;
        end
      end
      B_YEAR: begin
        if (days_q < ylen) begin
          // Years before 1980 have no FAT encoding.
          if (off_q < FatYearOff) begin
            zero_d  = 1'b1;
            state_d = B_DONE;
          end else begin
            state_d = B_MONTH;
          end
        end else begin
          days_d = days_q - ylen;
          off_d  = off_q + 8'd1;
        end
      end
      B_MONTH: begin
        if (month_q == LastMonth || days_q < mlen) begin
          state_d = B_DONE;
        end else begin
          days_d  = days_q - mlen;
          month_d = month_q + 4'd1;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          zres_d      = zero_q;
          if (zero_q) begin
            date_d = '0;
            time_d = '0;
          end else begin
            date_d = {fat_year[6:0], month_q + 4'd1, days_q[4:0] + 5'd1};
            time_d = {hour_q, min_q, hsec_q};
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign fat_date_o    = date_q;
  assign fat_time_o    = time_q;
  assign zero_result_o = zres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q  <= days_d;
    off_q   <= off_d;
    month_q <= month_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    hsec_q  <= hsec_d;
    zero_q  <= zero_d;
    date_q  <= date_d;
    time_q  <= time_d;
    zres_q  <= zres_d;
  end

endmodule

FILE: hdl/epoch_seconds_to_fat_datetime_top.sv
// Top level of the epoch-seconds to FAT date/time converter.
// Instantiates esfd_front, esfd_queue and esfd_back; uses esfd_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_stall_o   | epoch_seconds_i[31:0]
//  out     | output    | out_valid_o / out_stall_i | fat_date_o, fat_time_o, zero_result_o
//
// Front: accept, divide by 60, 60 and 24 (one reciprocal multiply each), then push.
// Back: pop, walk years from 1970 and months of the year reached, then output;
// a zero input skips both walks and goes straight to output.
// The back year walk sets the sustained rate; the front overlaps through the queue.
// Reset clears all control state; the queue and output register come up empty.
// A stalled result holds in the output register while the next item proceeds.
module epoch_seconds_to_fat_datetime_top import esfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [EpochW-1:0] epoch_seconds_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       fat_date_o,
  output logic [15:0]       fat_time_o,
  output logic              zero_result_o
);

  // Front to queue
  logic       push_valid, push_ready;
  esfd_item_t push_item;
  // Queue to back
  logic       pop_valid, pop_ready;
  esfd_item_t pop_item;

  // Split off seconds, minutes and hours; flag a zero input.
  esfd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .epoch_seconds_i (epoch_seconds_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_item_o     (push_item)
  );

  // Buffer up to two classified transactions so each side stalls on its own.
  esfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Walk years and months, then pack and hold the result.
  esfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_item_i    (pop_item),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fat_date_o    (fat_date_o),
    .fat_time_o    (fat_time_o),
    .zero_result_o (zero_result_o)
  );

endmodule

FILE: hdl/esfd_checker.sv
// Port-level checks for the converter top, attached by bind.
// Depends only on the top level's ports.
module esfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] fat_date_o,
  input logic [15:0] fat_time_o,
  input logic        zero_result_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A flagged result carries zero words.
  a_zero_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_result_o |-> fat_date_o == 16'd0 && fat_time_o == 16'd0)
    else $error("zero result with nonzero words");

  // A real date has month 1..12 and a nonzero day.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_result_o |->
      fat_date_o[8:5] != 4'd0 && fat_date_o[8:5] <= 4'd12 && fat_date_o[4:0] != 5'd0)
    else $error("month or day out of range");

  // Time fields stay within a day.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      fat_time_o[15:11] <= 5'd23 && fat_time_o[10:5] <= 6'd59 && fat_time_o[4:0] <= 5'd29)
    else $error("hour, minute or second out of range");

endmodule

bind epoch_seconds_to_fat_datetime_top esfd_checker u_esfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .fat_date_o    (fat_date_o),
  .fat_time_o    (fat_time_o),
  .zero_result_o (zero_result_o)
);

FILE: test/epoch_seconds_to_fat_datetime_checker.sv
`timescale 1ns / 100ps
// Checker for the epoch-seconds to FAT date/time converter: watches both channels,
// computes the expected FAT words for each accepted timestamp and compares in order.
// Depends on esfd_pkg for the port widths only.
module epoch_seconds_to_fat_datetime_checker import esfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [EpochW-1:0] epoch_seconds_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [15:0]       fat_date_i,
  input  logic [15:0]       fat_time_i,
  input  logic              zero_result_i,
  output int                mismatches_o,
  output int                pending_o,
  output int                converted_o
);

  localparam int unsigned UnixBaseYear = 1970;
  localparam int unsigned FatBaseYear  = 1980;
  localparam int unsigned SecsPerMin   = 60;
  localparam int unsigned MinsPerHour  = 60;
  localparam int unsigned HoursPerDay  = 24;
  localparam int unsigned DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [15:0] fat_date;
    logic [15:0] fat_time;
    logic        zero_result;
  } fat_stamp_t;

  fat_stamp_t awaited_stamps [$];

  function automatic bit gregorian_leap(int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  // Split the count into time of day, then walk whole years and whole months.
  function automatic fat_stamp_t epoch_to_fat(logic [EpochW-1:0] secs);
    fat_stamp_t  stamp;
    int unsigned rest, days, year, month, mlen;
    int unsigned hour, minute, second;
    stamp = '{fat_date: '0, fat_time: '0, zero_result: 1'b1};
    if (secs == '0) return stamp;
    second = secs % SecsPerMin;
    rest   = secs / SecsPerMin;
    minute = rest % MinsPerHour;
    rest   = rest / MinsPerHour;
    hour   = rest % HoursPerDay;
    days   = rest / HoursPerDay;
    year   = UnixBaseYear;
    while (days >= (gregorian_leap(year) ? 366 : 365)) begin
      days -= gregorian_leap(year) ? 366 : 365;
      year++;
    end
    if (year < FatBaseYear) return stamp;
    month = 0;
    mlen  = DaysInMonth[0];
    while (month < 11 && days >= mlen) begin
      days -= mlen;
      month++;
      mlen = (month == 1 && gregorian_leap(year)) ? 29 : DaysInMonth[month];
    end
    stamp.fat_date    = {7'(year - FatBaseYear), 4'(month + 1), 5'(days + 1)};
    stamp.fat_time    = {5'(hour), 6'(minute), 5'(second / 2)};
    stamp.zero_result = 1'b0;
    return stamp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fat_stamp_t want;
    int         errs;
    if (!rst_ni) begin
      awaited_stamps.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
      converted_o  <= 0;
    end else begin
      errs = mismatches_o;
      if (out_valid_i && !out_stall_i) begin
        if (awaited_stamps.size() == 0) begin
          $error("result with no timestamp outstanding: date %h time %h zero %b",
                 fat_date_i, fat_time_i, zero_result_i);
          errs++;
        end else begin
          want = awaited_stamps.pop_front();
          if (fat_date_i !== want.fat_date) begin
            $error("fat_date: expected %h, got %h", want.fat_date, fat_date_i);
            errs++;
          end
          if (fat_time_i !== want.fat_time) begin
            $error("fat_time: expected %h, got %h", want.fat_time, fat_time_i);
            errs++;
          end
          if (zero_result_i !== want.zero_result) begin
            $error("zero_result: expected %b, got %b", want.zero_result, zero_result_i);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_stamps.push_back(epoch_to_fat(epoch_seconds_i));
        converted_o <= converted_o + 1;
      end
      mismatches_o <= errs;
      pending_o    <= awaited_stamps.size();
    end
  end

endmodule

FILE: test/epoch_seconds_to_fat_datetime_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the epoch-seconds to FAT date/time converter: drives timestamps,
// throttles the result side and gives the verdict. Depends on esfd_pkg and the checker.
module epoch_seconds_to_fat_datetime_top_test;
  import esfd_pkg::*;

  // 1980-01-01 00:00:00, the first second that yields a FAT date.
  localparam logic [EpochW-1:0] FatEpochStart = 32'd315532800;
  localparam int unsigned SecsPerDay    = 86400;
  localparam int unsigned ItemsPerPhase = 300;
  // Watchdog limit, with a wide margin over the longest legal gap between transactions.
  localparam int unsigned IdleLimit     = 5000;
  localparam int unsigned DrainCycles   = 200;

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [EpochW-1:0] epoch_seconds_i = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic [15:0]       fat_date_o;
  logic [15:0]       fat_time_o;
  logic              zero_result_o;

  int          mismatches;
  int          pending;
  int          converted;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  epoch_seconds_to_fat_datetime_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .epoch_seconds_i(epoch_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fat_date_o     (fat_date_o),
    .fat_time_o     (fat_time_o),
    .zero_result_o  (zero_result_o)
  );

  epoch_seconds_to_fat_datetime_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .epoch_seconds_i(epoch_seconds_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fat_date_i     (fat_date_o),
    .fat_time_i     (fat_time_o),
    .zero_result_i  (zero_result_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .converted_o    (converted)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Throttle the result side; the percentage changes per phase, zero means never stall.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Watchdog: end the run when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("timeout after %0d cycles without a transaction", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one timestamp and hold it until accepted. Optional idle cycles go first,
  // so valid stays high between back-to-back transactions.
  task automatic send_timestamp(input logic [EpochW-1:0] secs);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= secs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  // The extra edge lets the checker count the transaction accepted last.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Pick a timestamp: mostly valid FAT range, plus pre-1980 values, zero,
  // day boundaries (midnight and the second before) and the full 32-bit range.
  task automatic random_timestamp(output logic [EpochW-1:0] secs);
    case ($urandom_range(9, 0))
      0: secs = $urandom();
      1: secs = $urandom_range(FatEpochStart - 1, 1);
      2: secs = $urandom_range(3, 0) == 0 ? '0 : $urandom_range(1, 0) + FatEpochStart - 1;
      3, 4: secs = $urandom_range(49710, 3652) * SecsPerDay - $urandom_range(1, 0);
      default: secs = $urandom_range(32'hFFFF_FFFF, FatEpochStart);
    endcase
  endtask

  initial begin
    logic [EpochW-1:0] secs;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed timestamps: zero, pre-1980, the FAT epoch, leap days, century
    // rules (2000 leap, 2100 not), odd seconds and the last 32-bit second.
    send_timestamp(32'd0);
    send_timestamp(32'd1);
    send_timestamp(32'd315532799);   // 1979-12-31 23:59:59
    send_timestamp(FatEpochStart);   // 1980-01-01 00:00:00
    send_timestamp(32'd315532801);   // odd second, halved down
    send_timestamp(32'd320716799);   // 1980-02-29 23:59:59
    send_timestamp(32'd320716800);   // 1980-03-01
    send_timestamp(32'd946684799);   // 1999-12-31 23:59:59
    send_timestamp(32'd951782400);   // 2000-02-29
    send_timestamp(32'd978307199);   // 2000-12-31 23:59:59
    send_timestamp(32'd1234567891);
    send_timestamp(32'h7FFF_FFFF);   // 2038-01-19 03:14:07
    send_timestamp(32'h8000_0000);
    send_timestamp(32'd4107542399);  // 2100-02-28 23:59:59
    send_timestamp(32'd4107542400);  // 2100-03-01, no leap day
    send_timestamp(32'd4102444800);  // 2100-01-01
    send_timestamp(32'hAAAA_AAAA);
    send_timestamp(32'h5555_5555);
    send_timestamp(32'hFFFF_FFFE);
    send_timestamp(32'hFFFF_FFFF);   // 2106-02-07 06:28:15
    drain_results();

    // Random phases: receiver throttled, then sender throttled, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 28; recv_stall_pct = 75; end
        1: begin send_idle_pct = 75; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        random_timestamp(secs);
        send_timestamp(secs);
      end
      drain_results();
    end

    // Let any late or spurious result show up before judging.
    repeat (DrainCycles) @(posedge clk_i);
    $display("Converted %0d timestamps: directed calendar corners, then random values",
             converted);
    $display("under sender throttling, receiver throttling and full-rate streaming.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/esfd_pkg.sv
hdl/esfd_front.sv
hdl/esfd_queue.sv
hdl/esfd_back.sv
hdl/epoch_seconds_to_fat_datetime_top.sv
hdl/esfd_checker.sv
test/epoch_seconds_to_fat_datetime_checker.sv
test/epoch_seconds_to_fat_datetime_top_test.sv
